// ----- rtl/smt_pkg.sv -----
// Shared types and codes for the sorted multiset table and its storage cells.
package smt_pkg;

   // Width of one stored value and of the request/response value fields.
   localparam int VALUE_W = 32;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;
   localparam int INDEX_W = 8;
   localparam int COUNT_W = 9;

   // Request action codes.
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

   // Operation broadcast to every cell of the chain.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   // Command bundle driven by the controller into the cell chain.
   typedef struct packed {
      cell_op_type op;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage

// ----- rtl/smt_cell.sv -----
// One storage cell of the sorted chain: holds a single entry and trades it with its neighbors.
module smt_cell (
   input  logic clock,
   input  smt_pkg::cell_cmd_type cmd,
   input  logic occupied,
   input  logic selected,
   input  logic prev_gt,
   input  logic signed [smt_pkg::VALUE_W-1:0] prev_entry,
   input  logic signed [smt_pkg::VALUE_W-1:0] next_entry,
   output logic signed [smt_pkg::VALUE_W-1:0] entry,
   output logic gt,
   output logic match,
   output logic [smt_pkg::VALUE_W-1:0] rd_data
);
   import smt_pkg::*;

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;

   // Local comparisons against the broadcast value.
   assign gt = occupied && (entry_ff > cmd.value);
   assign match = occupied && (entry_ff == cmd.value);
   assign entry = entry_ff;
   assign rd_data = selected ? entry_ff : '0;

   // Insert opens a slot after the larger entries; remove pulls the right neighbor in.
   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (!gt) begin
               if (prev_gt) begin
                  entry_in = cmd.value;
               end else begin
                  entry_in = prev_entry;
               end
            end
         end
         CELL_REMOVE: begin
            if (occupied && !gt) begin
               entry_in = next_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // The entry payload needs no reset; the fill count marks what is valid.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- rtl/sorted_multiset_table.sv -----
// Top level of the sorted multiset table: controller, fill count and the chain of cells.
//
//   channel   ports                                      handshake
//   request   req_action, req_value, req_index           start while busy is low
//   response  rsp_status, rsp_read_value, rsp_removed,   rsp_valid, one cycle
//             rsp_count
//
// An insert, a read or a no-op passes through the execute state to the response state,
// which raises the response strobe, and the block takes a new transaction once it is idle.
// A delete goes from execute to check, then through wait and check again for every entry
// removed, and ends in the response state, since the chain compacts by one position per
// step and the match check is registered.
// Reset clears the fill count and the controller; entry payloads are not cleared.
// The response is held one cycle only; the receiver cannot stall it.
module sorted_multiset_table #(
   parameter int CAPACITY = 256
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [smt_pkg::ACTION_W-1:0] req_action,
   input  logic signed [smt_pkg::VALUE_W-1:0] req_value,
   input  logic [smt_pkg::INDEX_W-1:0] req_index,
   output logic rsp_valid,
   output logic [smt_pkg::STATUS_W-1:0] rsp_status,
   output logic signed [smt_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [smt_pkg::COUNT_W-1:0] rsp_removed,
   output logic [smt_pkg::COUNT_W-1:0] rsp_count
);
   import smt_pkg::*;

   localparam int FILL_W = $clog2(CAPACITY + 1);

   // Controller states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_DCHECK = 3'd2;
   localparam logic [2:0] S_DWAIT = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [FILL_W-1:0] removed_ff;
   logic [FILL_W-1:0] removed_in;
   logic [ACTION_W-1:0] action_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [INDEX_W-1:0] index_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic [VALUE_W-1:0] rdval_ff;
   logic [VALUE_W-1:0] rdval_in;
   logic any_match_ff;

   cell_cmd_type cmd;
   logic accept;
   logic full;
   logic index_ok;
   logic any_match;
   logic [VALUE_W-1:0] rd_mux;

   logic signed [VALUE_W-1:0] cell_entry [CAPACITY];
   logic [CAPACITY-1:0] cell_gt;
   logic [CAPACITY-1:0] cell_match;
   logic [CAPACITY-1:0] cell_occ;
   logic [CAPACITY-1:0] cell_sel;
   logic [VALUE_W-1:0] cell_rd [CAPACITY];

   assign accept = start && !busy;
   assign busy = (state_ff != S_IDLE);
   assign full = (fill_ff == FILL_W'(CAPACITY));
   assign index_ok = (32'(index_ff) < 32'(fill_ff));

   // The chain of cells, each told whether it is occupied and whether a read selects it.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [FILL_W-1:0] POS = FILL_W'(i);
      localparam bit IN_RANGE = (i < (2 ** INDEX_W));
      logic prev_gt_w;
      logic signed [VALUE_W-1:0] prev_w;
      logic signed [VALUE_W-1:0] next_w;

      assign cell_occ[i] = (POS < fill_ff);
      assign cell_sel[i] = IN_RANGE && (INDEX_W'(i) == index_ff);

      if (i == 0) begin : g_first
         assign prev_gt_w = 1'b1;
         assign prev_w = cmd.value;
      end else begin : g_mid
         assign prev_gt_w = cell_gt[i-1];
         assign prev_w = cell_entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_w = cell_entry[i];
      end else begin : g_inner
         assign next_w = cell_entry[i+1];
      end

      smt_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (cell_occ[i]),
         .selected   (cell_sel[i]),
         .prev_gt    (prev_gt_w),
         .prev_entry (prev_w),
         .next_entry (next_w),
         .entry      (cell_entry[i]),
         .gt         (cell_gt[i]),
         .match      (cell_match[i]),
         .rd_data    (cell_rd[i])
      );
   end

   // Combine the per-cell read outputs; at most one cell is selected.
   always_comb begin
      rd_mux = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_mux = rd_mux | cell_rd[i];
      end
   end

   assign any_match = |cell_match;

   // Controller: one transaction at a time, with delete compacting one entry per step.
   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      removed_in = removed_ff;
      status_in = status_ff;
      rdval_in = rdval_ff;
      cmd.op = CELL_HOLD;
      cmd.value = value_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
               removed_in = '0;
               status_in = ST_OK;
               rdval_in = '0;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
            case (action_ff)
               ACT_INSERT: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.op = CELL_INSERT;
                     fill_in = fill_ff + 1'b1;
                  end
               end
               ACT_DELETE: begin
                  state_in = S_DCHECK;
               end
               ACT_READ: begin
                  if (index_ok) begin
                     rdval_in = rd_mux;
                  end else begin
                     status_in = ST_BAD_INDEX;
                  end
               end
               default: begin
                  status_in = ST_OK;
               end
            endcase
         end
         S_DCHECK: begin
            if (any_match_ff) begin
               cmd.op = CELL_REMOVE;
               fill_in = fill_ff - 1'b1;
               removed_in = removed_ff + 1'b1;
               state_in = S_DWAIT;
            end else begin
               status_in = (removed_ff == '0) ? ST_NOT_FOUND : ST_OK;
               state_in = S_RESP;
            end
         end
         S_DWAIT: begin
            state_in = S_DCHECK;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff <= '0;
         any_match_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         any_match_ff <= any_match;
      end
   end

   // Transaction payload and result registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         value_ff <= req_value;
         index_ff <= req_index;
      end
      removed_ff <= removed_in;
      status_ff <= status_in;
      rdval_ff <= rdval_in;
   end

   // Response ports.
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_status = status_ff;
   assign rsp_read_value = rdval_ff;
   assign rsp_removed = COUNT_W'(removed_ff);
   assign rsp_count = COUNT_W'(fill_ff);

   // The fill count never passes the capacity.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= CAPACITY)
      else $error("fill count beyond capacity");

   // A full status is only reported when the table really is full.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> full)
      else $error("full status with free space");

   // Each compaction step removes exactly one entry.
   a_remove_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DCHECK && any_match_ff) |=> (fill_ff == $past(fill_ff) - 1'b1))
      else $error("compaction step did not drop one entry");

   // An accepted transaction makes the block busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted transaction did not raise busy");

endmodule

// ----- sim/tb_sorted_multiset_table.sv -----
// Self-checking testbench for the sorted multiset table: directed table, then random operations.
module tb_sorted_multiset_table;
   import smt_pkg::*;

   localparam int TABLE_DEPTH = 256;
   localparam int RANDOM_ITEMS = 700;
   localparam int NUM_STEPS = 24;
   localparam int POOL_SIZE = 12;
   // A delete that empties a full table is the slowest operation.
   localparam int SETTLE_CYCLES = 4 + 2 * TABLE_DEPTH + 16;
   localparam int CYCLE_LIMIT = 2000000;

   // The unused action code is a no-op that still reports the count.
   localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;

   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_NEG1 = -32'sd1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic signed [VALUE_W-1:0] read_value;
      logic [COUNT_W-1:0] removed;
      logic [COUNT_W-1:0] count;
   } reply_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic signed [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
      logic known;
      reply_type reply;
   } step_type;

   typedef enum {
      PH_FILL,
      PH_FULL,
      PH_MIX,
      PH_DRAIN
   } phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [ACTION_W-1:0] req_action = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic [INDEX_W-1:0] req_index = '0;
   logic rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic signed [VALUE_W-1:0] rsp_read_value;
   logic [COUNT_W-1:0] rsp_removed;
   logic [COUNT_W-1:0] rsp_count;

   // Shadow copy of the table contents, largest first.
   logic signed [VALUE_W-1:0] sorted_entries[$];
   reply_type pending_replies[$];
   logic signed [VALUE_W-1:0] value_pool[POOL_SIZE];
   int mismatches = 0;
   int cycle_count = 0;
   int burst_left = 1;

   // Directed operations; replies are written out only where they are obvious.
   step_type steps[NUM_STEPS] = '{
      '{ACT_READ, 32'sd0, 8'd0, 1'b1, '{ST_BAD_INDEX, 32'sd0, 9'd0, 9'd0}},
      '{ACT_DELETE, 32'sd5, 8'd0, 1'b1, '{ST_NOT_FOUND, 32'sd0, 9'd0, 9'd0}},
      '{ACT_NOP, 32'sd0, 8'd0, 1'b1, '{ST_OK, 32'sd0, 9'd0, 9'd0}},
      '{ACT_INSERT, VAL_MAX, 8'd0, 1'b1, '{ST_OK, 32'sd0, 9'd0, 9'd1}},
      '{ACT_INSERT, VAL_MIN, 8'd255, 1'b1, '{ST_OK, 32'sd0, 9'd0, 9'd2}},
      '{ACT_INSERT, 32'sd0, 8'd0, 1'b1, '{ST_OK, 32'sd0, 9'd0, 9'd3}},
      '{ACT_INSERT, VAL_NEG1, 8'd0, 1'b1, '{ST_OK, 32'sd0, 9'd0, 9'd4}},
      '{ACT_INSERT, 32'sd0, 8'd0, 1'b0, '0},
      '{ACT_INSERT, 32'sd1, 8'd0, 1'b0, '0},
      '{ACT_READ, 32'sd0, 8'd0, 1'b1, '{ST_OK, VAL_MAX, 9'd0, 9'd6}},
      '{ACT_READ, 32'sd0, 8'd5, 1'b1, '{ST_OK, VAL_MIN, 9'd0, 9'd6}},
      '{ACT_READ, 32'sd0, 8'd2, 1'b0, '0},
      '{ACT_READ, 32'sd0, 8'd6, 1'b1, '{ST_BAD_INDEX, 32'sd0, 9'd0, 9'd6}},
      '{ACT_READ, VAL_NEG1, 8'd255, 1'b1, '{ST_BAD_INDEX, 32'sd0, 9'd0, 9'd6}},
      '{ACT_DELETE, 32'sd0, 8'd0, 1'b1, '{ST_OK, 32'sd0, 9'd2, 9'd4}},
      '{ACT_DELETE, 32'sd0, 8'd0, 1'b1, '{ST_NOT_FOUND, 32'sd0, 9'd0, 9'd4}},
      '{ACT_DELETE, VAL_MIN, 8'd0, 1'b1, '{ST_OK, 32'sd0, 9'd1, 9'd3}},
      '{ACT_NOP, VAL_NEG1, 8'd255, 1'b1, '{ST_OK, 32'sd0, 9'd0, 9'd3}},
      '{ACT_INSERT, VAL_NEG1, 8'd0, 1'b0, '0},
      '{ACT_DELETE, VAL_NEG1, 8'd0, 1'b1, '{ST_OK, 32'sd0, 9'd2, 9'd2}},
      '{ACT_READ, 32'sd0, 8'd1, 1'b0, '0},
      '{ACT_DELETE, VAL_MAX, 8'd0, 1'b1, '{ST_OK, 32'sd0, 9'd1, 9'd1}},
      '{ACT_DELETE, 32'sd1, 8'd0, 1'b1, '{ST_OK, 32'sd0, 9'd1, 9'd0}},
      '{ACT_READ, 32'sd0, 8'd0, 1'b1, '{ST_BAD_INDEX, 32'sd0, 9'd0, 9'd0}}
   };

   sorted_multiset_table #(
      .CAPACITY(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_value(req_value),
      .req_index(req_index),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_read_value(rsp_read_value),
      .rsp_removed(rsp_removed),
      .rsp_count(rsp_count)
   );

   always #2 clock = ~clock;

   // Applies one operation to the shadow table and returns the reply it should produce.
   function automatic reply_type apply_op(input logic [ACTION_W-1:0] action,
                                          input logic signed [VALUE_W-1:0] value,
                                          input logic [INDEX_W-1:0] index);
      reply_type reply;
      logic signed [VALUE_W-1:0] kept[$];
      int pos;
      reply = '0;
      reply.status = ST_OK;
      case (action)
         ACT_INSERT: begin
            if (sorted_entries.size() >= TABLE_DEPTH) begin
               reply.status = ST_FULL;
            end else begin
               // New value goes after every strictly larger entry.
               pos = 0;
               while (pos < sorted_entries.size() && sorted_entries[pos] > value) pos++;
               sorted_entries.insert(pos, value);
            end
         end
         ACT_DELETE: begin
            foreach (sorted_entries[i]) begin
               if (sorted_entries[i] != value) kept.push_back(sorted_entries[i]);
            end
            reply.removed = COUNT_W'(sorted_entries.size() - kept.size());
            if (kept.size() == sorted_entries.size()) reply.status = ST_NOT_FOUND;
            sorted_entries = kept;
         end
         ACT_READ: begin
            if (int'(index) < sorted_entries.size()) reply.read_value = sorted_entries[index];
            else reply.status = ST_BAD_INDEX;
         end
         default: begin
         end
      endcase
      reply.count = COUNT_W'(sorted_entries.size());
      return reply;
   endfunction

   // Presents one transaction from a falling edge and holds it until the block takes it.
   task automatic issue(input logic [ACTION_W-1:0] action,
                        input logic signed [VALUE_W-1:0] value,
                        input logic [INDEX_W-1:0] index,
                        input logic known,
                        input reply_type literal);
      reply_type predicted;
      start <= 1'b1;
      req_action <= action;
      req_value <= value;
      req_index <= index;
      do @(posedge clock); while (busy);
      predicted = apply_op(action, value, index);
      pending_replies.push_back(known ? literal : predicted);
      @(negedge clock);
   endtask

   // Sender pacing: bursts of back-to-back transactions separated by idle gaps.
   task automatic pace();
      int gap;
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
   endtask

   // Values mostly come from a small pool so that duplicates build up.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (roll == 4 && sorted_entries.size() > 0)
         return sorted_entries[$urandom_range(0, sorted_entries.size() - 1)];
      return $urandom;
   endfunction

   task automatic check_field(input string name, input logic signed [63:0] expected,
                              input logic signed [63:0] actual);
      if (expected !== actual) begin
         mismatches++;
         $error("%s: expected %0d, got %0d", name, expected, actual);
      end
   endtask

   // Response checker: every strobe must match the oldest outstanding reply.
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid) begin
         if (pending_replies.size() == 0) begin
            mismatches++;
            $error("response strobe with no transaction outstanding");
         end else begin
            want = pending_replies.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("read_value", want.read_value, rsp_read_value);
            check_field("removed", want.removed, rsp_removed);
            check_field("count", want.count, rsp_count);
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_sorted_multiset_table: FAIL");
         $finish;
      end
   end

   initial begin
      phase_type phase;
      int phase_items;
      int roll;
      logic [ACTION_W-1:0] action;
      logic signed [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;

      value_pool[0] = VAL_MAX;
      value_pool[1] = VAL_MIN;
      value_pool[2] = 32'sd0;
      value_pool[3] = VAL_NEG1;
      value_pool[4] = 32'sd1;
      for (int i = 5; i < POOL_SIZE; i++) value_pool[i] = $urandom;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table.
      foreach (steps[i]) begin
         issue(steps[i].action, steps[i].value, steps[i].index, steps[i].known,
               steps[i].reply);
         pace();
      end

      // Random part: fill to capacity, dwell while full, mix, then drain.
      phase = PH_FILL;
      phase_items = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase == PH_FILL && sorted_entries.size() >= TABLE_DEPTH) begin
            phase = PH_FULL;
            phase_items = 0;
         end else if (phase == PH_FULL && phase_items >= 30) begin
            phase = PH_MIX;
            phase_items = 0;
         end else if (phase == PH_MIX && phase_items >= 200) begin
            phase = PH_DRAIN;
            phase_items = 0;
         end
         phase_items++;

         roll = $urandom_range(0, 99);
         case (phase)
            PH_FILL: action = (roll < 85) ? ACT_INSERT : (roll < 90) ? ACT_READ :
                              (roll < 96) ? ACT_DELETE : ACT_NOP;
            PH_FULL: action = (roll < 50) ? ACT_INSERT : (roll < 85) ? ACT_READ :
                              (roll < 92) ? ACT_DELETE : ACT_NOP;
            PH_MIX: action = (roll < 35) ? ACT_INSERT : (roll < 65) ? ACT_READ :
                             (roll < 93) ? ACT_DELETE : ACT_NOP;
            default: action = (roll < 15) ? ACT_INSERT : (roll < 45) ? ACT_READ :
                              (roll < 96) ? ACT_DELETE : ACT_NOP;
         endcase

         value = pick_value();
         index = INDEX_W'($urandom_range(0, 255));
         // Deletes mostly target values that are present; reads mostly valid positions.
         if (action == ACT_DELETE && sorted_entries.size() > 0 && $urandom_range(0, 99) < 65)
            value = sorted_entries[$urandom_range(0, sorted_entries.size() - 1)];
         if (action == ACT_READ && sorted_entries.size() > 0 && $urandom_range(0, 99) < 70)
            index = INDEX_W'($urandom_range(0, sorted_entries.size() - 1));

         issue(action, value, index, 1'b0, '0);
         pace();
      end

      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("tb_sorted_multiset_table: PASS");
      end else begin
         $display("tb_sorted_multiset_table: FAIL");
      end
      $finish;
   end

endmodule
